### design/lfpd_pkg.sv
// Shared types and constants for the line-follow PID motor drive.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lfpd_pkg;

  // Fixed-point scaling of the gains and the duty ceiling.
  localparam int GAIN_FRAC_BITS = 16;
  localparam int DUTY_MAX       = 255;

  // Field widths.
  localparam int POS_W   = 12;
  localparam int SPEED_W = 8;
  localparam int GAIN_W  = 24;
  localparam int DUTY_W  = 8;
  localparam int CORR_W  = 16;

  // Datapath widths.
  localparam int ERR_W    = POS_W + 1;
  localparam int ACC_W    = 16;
  localparam int DIFF_W   = ERR_W + 1;
  localparam int PROD_P_W = GAIN_W + ERR_W;
  localparam int PROD_I_W = GAIN_W + ACC_W;
  localparam int PROD_D_W = GAIN_W + DIFF_W;
  localparam int SUM_W    = PROD_I_W + 2;
  localparam int MOTOR_W  = CORR_W + 1;

  // Configuration port.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_CENTER   = 3'd0,
    REG_BASE     = 3'd1,
    REG_GAIN_P   = 3'd2,
    REG_GAIN_I   = 3'd3,
    REG_GAIN_D   = 3'd4,
    REG_REVERSE  = 3'd5
  } reg_idx_t;

  localparam logic [POS_W-1:0]   CENTER_RST = POS_W'(1500);
  localparam logic [SPEED_W-1:0] BASE_RST   = SPEED_W'(85);
  localparam logic [GAIN_W-1:0]  GAIN_P_RST = GAIN_W'(5571);
  localparam logic [GAIN_W-1:0]  GAIN_I_RST = GAIN_W'(131);
  localparam logic [GAIN_W-1:0]  GAIN_D_RST = GAIN_W'(197);

  // Per-stage pipeline control: load the stage, and whether the item
  // offered from the stage before it is real.
  typedef struct packed {
    logic load;
    logic valid;
  } stage_ctl_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [POS_W-1:0]   center_position;
    logic [SPEED_W-1:0] base_speed;
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic               reverse_mode;
  } cfg_t;

endpackage

`default_nettype wire

### design/lfpd_apb_regs.sv
// APB configuration registers for the line-follow PID motor drive.
// Depends on lfpd_pkg for the register map and the reset values.
`default_nettype none

module lfpd_apb_regs
  import lfpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_position <= CENTER_RST;
      cfg.base_speed      <= BASE_RST;
      cfg.gain_p          <= GAIN_P_RST;
      cfg.gain_i          <= GAIN_I_RST;
      cfg.gain_d          <= GAIN_D_RST;
      cfg.reverse_mode    <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_CENTER:  cfg.center_position <= pwdata[POS_W-1:0];
        REG_BASE:    cfg.base_speed      <= pwdata[SPEED_W-1:0];
        REG_GAIN_P:  cfg.gain_p          <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:  cfg.gain_i          <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:  cfg.gain_d          <= pwdata[GAIN_W-1:0];
        REG_REVERSE: cfg.reverse_mode    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CENTER:  prdata = DATA_W'(cfg.center_position);
      REG_BASE:    prdata = DATA_W'(cfg.base_speed);
      REG_GAIN_P:  prdata = DATA_W'(cfg.gain_p);
      REG_GAIN_I:  prdata = DATA_W'(cfg.gain_i);
      REG_GAIN_D:  prdata = DATA_W'(cfg.gain_d);
      REG_REVERSE: prdata = DATA_W'(cfg.reverse_mode);
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### design/lfpd_err_stage.sv
// Error, integral and derivative-difference stage; owns the controller state.
// Depends on lfpd_pkg for widths and the stage control type.
`default_nettype none

module lfpd_err_stage
  import lfpd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire stage_ctl_t               ctl,
  input  wire logic                     cmd,
  input  wire logic [POS_W-1:0]         line_position,
  input  wire logic [POS_W-1:0]         center_position,
  output logic signed [ERR_W-1:0]       err_q,
  output logic signed [ACC_W-1:0]       acc_q,
  output logic signed [DIFF_W-1:0]      diff_q
);

  logic signed [ACC_W-1:0]  integral_sum;
  logic signed [ERR_W-1:0]  previous_error;

  logic signed [ERR_W-1:0]  err;
  logic signed [ACC_W:0]    acc_raw;
  logic signed [ACC_W-1:0]  acc_sat;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [DIFF_W-1:0] diff;
  logic                     opposite;

  always_comb begin
    err     = $signed({1'b0, center_position}) - $signed({1'b0, line_position});
    acc_raw = (ACC_W+1)'(err) + (ACC_W+1)'(integral_sum);
    // saturate to int16
    if (acc_raw[ACC_W] != acc_raw[ACC_W-1]) begin
      acc_sat = acc_raw[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_raw[ACC_W-1:0];
    end
    // drop the integral when it fights the error
    opposite = (err[ERR_W-1] && !acc_sat[ACC_W-1] && (acc_sat != '0))
            || (!err[ERR_W-1] && (err != '0) && acc_sat[ACC_W-1]);
    acc_next = opposite ? '0 : acc_sat;
    diff     = DIFF_W'(err) - DIFF_W'(previous_error);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum   <= '0;
      previous_error <= '0;
    end else if (ctl.load && ctl.valid) begin
      if (cmd) begin
        integral_sum   <= '0;
        previous_error <= '0;
      end else begin
        integral_sum   <= acc_next;
        previous_error <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      err_q  <= err;
      acc_q  <= acc_next;
      diff_q <= diff;
    end
  end

endmodule

`default_nettype wire

### design/lfpd_mult_stage.sv
// Gain products and their sum, two register stages.
// Depends on lfpd_pkg for widths.
`default_nettype none

module lfpd_mult_stage
  import lfpd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 load_prod,
  input  wire logic                 load_sum,
  input  wire logic signed [ERR_W-1:0]  err,
  input  wire logic signed [ACC_W-1:0]  acc,
  input  wire logic signed [DIFF_W-1:0] diff,
  input  wire logic [GAIN_W-1:0]    gain_p,
  input  wire logic [GAIN_W-1:0]    gain_i,
  input  wire logic [GAIN_W-1:0]    gain_d,
  output logic signed [SUM_W-1:0]   sum_q
);

  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_I_W-1:0] prod_i;
  logic signed [PROD_D_W-1:0] prod_d;
  logic signed [PROD_P_W-1:0] prod_p_next;
  logic signed [PROD_I_W-1:0] prod_i_next;
  logic signed [PROD_D_W-1:0] prod_d_next;
  logic signed [SUM_W-1:0]    sum_next;

  always_comb begin
    prod_p_next = PROD_P_W'($signed({1'b0, gain_p})) * PROD_P_W'(err);
    prod_i_next = PROD_I_W'($signed({1'b0, gain_i})) * PROD_I_W'(acc);
    prod_d_next = PROD_D_W'($signed({1'b0, gain_d})) * PROD_D_W'(diff);
    sum_next    = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
  end

  always_ff @(posedge clk) begin
    if (load_prod) begin
      prod_p <= prod_p_next;
      prod_i <= prod_i_next;
      prod_d <= prod_d_next;
    end
    if (load_sum) begin
      sum_q <= sum_next;
    end
  end

endmodule

`default_nettype wire

### design/lfpd_drive_stage.sv
// Scale and saturate the correction, split both motor speeds; result register.
// Depends on lfpd_pkg for widths, GAIN_FRAC_BITS and DUTY_MAX.
`default_nettype none

module lfpd_drive_stage
  import lfpd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    load,
  input  wire logic signed [SUM_W-1:0] sum,
  input  wire logic [SPEED_W-1:0]      base_speed,
  input  wire logic                    reverse_mode,
  output logic                         motor_a_forward,
  output logic [DUTY_W-1:0]            motor_a_duty,
  output logic                         motor_b_forward,
  output logic [DUTY_W-1:0]            motor_b_duty,
  output logic signed [CORR_W-1:0]     correction
);

  localparam int SHIFT_W = SUM_W - GAIN_FRAC_BITS;

  logic [SUM_W-1:0]          mag;
  logic [SHIFT_W-1:0]        scaled;
  logic signed [CORR_W-1:0]  corr;
  logic signed [MOTOR_W-1:0] speed_a;
  logic signed [MOTOR_W-1:0] speed_b;
  logic [MOTOR_W-1:0]        mag_a;
  logic [MOTOR_W-1:0]        mag_b;
  logic [MOTOR_W-1:0]        sat_a;
  logic [MOTOR_W-1:0]        sat_b;

  always_comb begin
    // truncate toward zero: scale the magnitude, then restore the sign
    mag    = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    scaled = mag[SUM_W-1:GAIN_FRAC_BITS];
    if (!sum[SUM_W-1]) begin
      corr = (scaled > SHIFT_W'(32767)) ? {1'b0, {(CORR_W-1){1'b1}}}
                                        : $signed(scaled[CORR_W-1:0]);
    end else begin
      corr = (scaled > SHIFT_W'(32768)) ? {1'b1, {(CORR_W-1){1'b0}}}
                                        : -$signed(scaled[CORR_W-1:0]);
    end

    speed_a = $signed(MOTOR_W'(base_speed)) - MOTOR_W'(corr);
    speed_b = $signed(MOTOR_W'(base_speed)) + MOTOR_W'(corr);
    mag_a   = speed_a[MOTOR_W-1] ? MOTOR_W'(-speed_a) : MOTOR_W'(speed_a);
    mag_b   = speed_b[MOTOR_W-1] ? MOTOR_W'(-speed_b) : MOTOR_W'(speed_b);
    sat_a   = (mag_a > MOTOR_W'(DUTY_MAX)) ? MOTOR_W'(DUTY_MAX) : mag_a;
    sat_b   = (mag_b > MOTOR_W'(DUTY_MAX)) ? MOTOR_W'(DUTY_MAX) : mag_b;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      motor_a_forward <= !speed_a[MOTOR_W-1] ^ reverse_mode;
      motor_a_duty    <= sat_a[DUTY_W-1:0];
      motor_b_forward <= !speed_b[MOTOR_W-1] ^ reverse_mode;
      motor_b_duty    <= sat_b[DUTY_W-1:0];
      correction      <= corr;
    end
  end

endmodule

`default_nettype wire

### design/line_follow_pid_motor_drive_top.sv
// Top level of the line-follow PID motor drive: handshake, pipeline control.
// Depends on lfpd_pkg and the lfpd_apb_regs, err, mult and drive stages.
//
// Usage:
//  - Input channel (in_valid / in_stall) carries one item: cmd and
//    line_position. cmd 0 is a position sample and yields one result item;
//    cmd 1 clears the integral and the last error and yields nothing.
//  - Output channel (out_valid / out_stall) carries motor A and B direction
//    and duty plus the signed correction.
//  - From input acceptance to out_valid an item passes the input register,
//    error/integral stage, gain products, product sum and result register.
//  - One item per cycle while out_stall is low. The integral and last error
//    update in the single error stage, so back-to-back samples see fresh state.
//  - When out_stall is high the result register holds; earlier stages keep
//    filling bubbles, and in_stall rises only once every stage is occupied.
//  - Reset (rst, synchronous) empties the pipeline, zeroes the integral and
//    last error and loads the register defaults.
//  - Configuration goes through the APB port, registers at 4*index; change
//    it only while no item is in flight.
`default_nettype none

module line_follow_pid_motor_drive_top
  import lfpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              cmd,
  input  wire logic [POS_W-1:0]  line_position,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   motor_a_forward,
  output logic [DUTY_W-1:0]      motor_a_duty,
  output logic                   motor_b_forward,
  output logic [DUTY_W-1:0]      motor_b_duty,
  output logic signed [CORR_W-1:0] correction,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  cfg_t cfg;

  // stage valids: input register, error stage, products, sum, result
  logic v0, v1, v2, v3, v4;
  logic free0, free1, free2, free3, free4;

  logic             cmd_q;
  logic [POS_W-1:0] pos_q;

  logic signed [ERR_W-1:0]  err;
  logic signed [ACC_W-1:0]  acc;
  logic signed [DIFF_W-1:0] diff;
  logic signed [SUM_W-1:0]  sum;

  stage_ctl_t err_ctl;

  // A stage may load when it is empty or its item moves on this cycle.
  always_comb begin
    free4 = !v4 || !out_stall;
    free3 = !v3 || free4;
    free2 = !v2 || free3;
    free1 = !v1 || free2;
    free0 = !v0 || free1;
  end

  assign in_stall      = !free0;
  assign out_valid     = v4;
  assign err_ctl.load  = free1;
  assign err_ctl.valid = v0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (free0) v0 <= in_valid;
      // drop clear commands once they have reset the state
      if (free1) v1 <= v0 && !cmd_q;
      if (free2) v2 <= v1;
      if (free3) v3 <= v2;
      if (free4) v4 <= v3;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (free0) begin
      cmd_q <= cmd;
      pos_q <= line_position;
    end
  end

  lfpd_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lfpd_err_stage u_err (
    .clk             (clk),
    .rst             (rst),
    .ctl             (err_ctl),
    .cmd             (cmd_q),
    .line_position   (pos_q),
    .center_position (cfg.center_position),
    .err_q           (err),
    .acc_q           (acc),
    .diff_q          (diff)
  );

  lfpd_mult_stage u_mult (
    .clk       (clk),
    .load_prod (free2),
    .load_sum  (free3),
    .err       (err),
    .acc       (acc),
    .diff      (diff),
    .gain_p    (cfg.gain_p),
    .gain_i    (cfg.gain_i),
    .gain_d    (cfg.gain_d),
    .sum_q     (sum)
  );

  lfpd_drive_stage u_drive (
    .clk             (clk),
    .load            (free4),
    .sum             (sum),
    .base_speed      (cfg.base_speed),
    .reverse_mode    (cfg.reverse_mode),
    .motor_a_forward (motor_a_forward),
    .motor_a_duty    (motor_a_duty),
    .motor_b_forward (motor_b_forward),
    .motor_b_duty    (motor_b_duty),
    .correction      (correction)
  );

endmodule

`default_nettype wire

### design/lfpd_checker.sv
// Port-level checks for the line-follow PID motor drive, bound to the top.
// Depends on lfpd_pkg for widths.
`default_nettype none

module lfpd_checker
  import lfpd_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic                    motor_a_forward,
  input wire logic [DUTY_W-1:0]       motor_a_duty,
  input wire logic                    motor_b_forward,
  input wire logic [DUTY_W-1:0]       motor_b_duty,
  input wire logic signed [CORR_W-1:0] correction
);

  // a result is held until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

  // zero correction drives both motors alike
  a_zero_corr: assert property (@(posedge clk) disable iff (rst)
    out_valid && (correction == '0) |->
      (motor_a_duty == motor_b_duty) && (motor_a_forward == motor_b_forward))
    else $error("motors differ with zero correction");

  // positive correction makes motor B speed at least one
  a_pos_corr: assert property (@(posedge clk) disable iff (rst)
    out_valid && !correction[CORR_W-1] && (correction != '0) |-> (motor_b_duty != '0))
    else $error("motor B idle with positive correction");

  // negative correction makes motor A speed at least one
  a_neg_corr: assert property (@(posedge clk) disable iff (rst)
    out_valid && correction[CORR_W-1] |-> (motor_a_duty != '0))
    else $error("motor A idle with negative correction");

endmodule

bind line_follow_pid_motor_drive_top lfpd_checker u_lfpd_checker (.*);

`default_nettype wire

### sim/line_follow_pid_motor_drive_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the line-follow PID motor drive top level.
// Depends on lfpd_pkg and line_follow_pid_motor_drive_top and its stages.

module line_follow_pid_motor_drive_top_tb;
  import lfpd_pkg::*;

  // Run limits. The slowest correct run ends well within CYCLE_LIMIT;
  // SETTLE_CYCLES covers the pipeline depth so that a trailing clear item
  // has left the block before any register write.
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_REPORTS   = 10;

  localparam longint CORR_MAX = 32767;
  localparam longint CORR_MIN = -32768;
  localparam int     POS_FULL = (1 << POS_W) - 1;
  localparam int     POS_SPAN = 3000;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  // One input item as the driver presents it.
  typedef struct packed {
    cmd_t             cmd;
    logic [POS_W-1:0] pos;
  } sample_t;

  // One result item: both motor commands plus the correction.
  typedef struct packed {
    logic                     a_fwd;
    logic [DUTY_W-1:0]        a_duty;
    logic                     b_fwd;
    logic [DUTY_W-1:0]        b_duty;
    logic signed [CORR_W-1:0] corr;
  } motor_cmd_t;

  // Clock, reset and every block input start at a known value.
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              cmd = 1'b0;
  logic [POS_W-1:0]  line_position = '0;
  logic              out_stall = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;

  wire logic                     in_stall;
  wire logic                     out_valid;
  wire logic                     motor_a_forward;
  wire logic [DUTY_W-1:0]        motor_a_duty;
  wire logic                     motor_b_forward;
  wire logic [DUTY_W-1:0]        motor_b_duty;
  wire logic signed [CORR_W-1:0] correction;
  wire logic [DATA_W-1:0]        prdata;
  wire logic                     pready;

  // Items waiting for the driver, and motor commands waiting for the block.
  sample_t    sample_q[$];
  motor_cmd_t motor_cmd_q[$];

  // Predictor copy of the register file and of the controller state.
  logic [POS_W-1:0]        set_center  = CENTER_RST;
  logic [SPEED_W-1:0]      set_base    = BASE_RST;
  logic [GAIN_W-1:0]       set_gain_p  = GAIN_P_RST;
  logic [GAIN_W-1:0]       set_gain_i  = GAIN_I_RST;
  logic [GAIN_W-1:0]       set_gain_d  = GAIN_D_RST;
  logic                    set_reverse = 1'b0;
  logic signed [ACC_W-1:0] integ_acc   = '0;
  logic signed [ERR_W-1:0] last_err    = '0;

  int   sender_idle_pct    = 0;
  int   receiver_stall_pct = 0;
  int   walk_pos           = 1500;
  int   mismatch_count     = 0;
  int   cycle_count        = 0;
  logic in_taken           = 1'b0;

  line_follow_pid_motor_drive_top dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .line_position   (line_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .motor_a_forward (motor_a_forward),
    .motor_a_duty    (motor_a_duty),
    .motor_b_forward (motor_b_forward),
    .motor_b_duty    (motor_b_duty),
    .correction      (correction),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic longint clip16(longint v);
    if (v > CORR_MAX) return CORR_MAX;
    if (v < CORR_MIN) return CORR_MIN;
    return v;
  endfunction

  // Split a signed speed into {forward, duty}. Zero counts as forward;
  // reverse mode flips the direction bit, never the duty.
  function automatic logic [DUTY_W:0] split_speed(longint speed);
    longint mag;
    logic   fwd;
    mag = (speed < 0) ? -speed : speed;
    if (mag > longint'(DUTY_MAX)) mag = longint'(DUTY_MAX);
    fwd = (speed >= 0) ^ set_reverse;
    return {fwd, DUTY_W'(mag)};
  endfunction

  // Advance the controller state by one accepted item and queue the motor
  // command it must produce. A clear item resets the state and yields nothing.
  task automatic track_sample(input sample_t s);
    longint     err;
    longint     acc;
    longint     sum;
    longint     mag;
    longint     corr;
    motor_cmd_t m;
    if (s.cmd == CMD_CLEAR) begin
      integ_acc = '0;
      last_err  = '0;
      return;
    end
    err = longint'(set_center) - longint'(s.pos);
    acc = clip16(err + longint'(integ_acc));
    // Drop the integral when it disagrees in sign with the error.
    if (err * acc < 0) acc = 0;
    sum = longint'(set_gain_p) * err
        + longint'(set_gain_i) * acc
        + longint'(set_gain_d) * (err - longint'(last_err));
    // Truncate toward zero: shift the magnitude, then restore the sign.
    mag  = (sum < 0) ? -sum : sum;
    mag  = mag >>> GAIN_FRAC_BITS;
    corr = clip16((sum < 0) ? -mag : mag);
    integ_acc = ACC_W'(acc);
    last_err  = ERR_W'(err);
    {m.a_fwd, m.a_duty} = split_speed(longint'(set_base) - corr);
    {m.b_fwd, m.b_duty} = split_speed(longint'(set_base) + corr);
    m.corr = CORR_W'(corr);
    motor_cmd_q.push_back(m);
  endtask

  task automatic check_motor_cmd(input motor_cmd_t got);
    motor_cmd_t want;
    if (motor_cmd_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("ERROR: result with nothing expected: A %0d/%0d B %0d/%0d corr %0d",
                 got.a_fwd, got.a_duty, got.b_fwd, got.b_duty, $signed(got.corr));
      return;
    end
    want = motor_cmd_q.pop_front();
    if (got.a_fwd !== want.a_fwd || got.a_duty !== want.a_duty ||
        got.b_fwd !== want.b_fwd || got.b_duty !== want.b_duty ||
        got.corr !== want.corr) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("ERROR: expected A %0d/%0d B %0d/%0d corr %0d, got A %0d/%0d B %0d/%0d corr %0d",
                 want.a_fwd, want.a_duty, want.b_fwd, want.b_duty, $signed(want.corr),
                 got.a_fwd, got.a_duty, got.b_fwd, got.b_duty, $signed(got.corr));
    end
  endtask

  // ---------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge
  // ---------------------------------------------------------------------

  // Check the result before tracking the new item, so a result that arrives
  // with nothing queued is never matched against the item just accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall)
        check_motor_cmd({motor_a_forward, motor_a_duty, motor_b_forward,
                         motor_b_duty, correction});
      if (in_valid && !in_stall)
        track_sample(sample_t'({cmd, line_position}));
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL line_follow_pid_motor_drive_top");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Driver: change inputs at the falling edge
  // ---------------------------------------------------------------------

  // Hold the current item until it is taken; only then pick the next one or
  // idle. The idle decision never looks at in_stall.
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          {cmd, line_position} <= sample_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------

  function automatic void set_idle(idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        sender_idle_pct    = 77;
        receiver_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 77;
      end
      IDLE_BOTH: begin
        sender_idle_pct    = 20;
        receiver_stall_pct = 20;
      end
      default: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
    endcase
  endfunction

  function automatic void queue_item(cmd_t c, int pos);
    sample_t s;
    s.cmd = c;
    s.pos = POS_W'(pos);
    sample_q.push_back(s);
  endfunction

  // Mostly a random walk so the error keeps its sign long enough to wind the
  // integral to saturation; the rest jumps within 0..POS_SPAN or all 12 bits.
  function automatic sample_t random_sample();
    sample_t s;
    int      pick;
    s.cmd = ($urandom_range(99) < 4) ? CMD_CLEAR : CMD_SAMPLE;
    pick  = $urandom_range(99);
    if (pick < 15)
      walk_pos = $urandom_range(POS_FULL);
    else if (pick < 40)
      walk_pos = $urandom_range(POS_SPAN);
    else
      walk_pos = walk_pos + int'($urandom_range(80)) - 40;
    if (walk_pos < 0) walk_pos = 0;
    if (walk_pos > POS_FULL) walk_pos = POS_FULL;
    s.pos = POS_W'(walk_pos);
    return s;
  endfunction

  // Gains spread over every magnitude, from zero up to all ones.
  function automatic logic [GAIN_W-1:0] random_gain();
    return GAIN_W'($urandom & ((32'd1 << $urandom_range(GAIN_W)) - 32'd1));
  endfunction

  // Wait until every item is taken and every result is in, then let a
  // trailing clear item drain out of the pipeline.
  task automatic wait_idle();
    do @(posedge clk);
    while (sample_q.size() != 0 || in_valid || motor_cmd_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB write: setup cycle, then access cycle until pready.
  task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    case (idx)
      REG_CENTER:  set_center  = value[POS_W-1:0];
      REG_BASE:    set_base    = value[SPEED_W-1:0];
      REG_GAIN_P:  set_gain_p  = value[GAIN_W-1:0];
      REG_GAIN_I:  set_gain_i  = value[GAIN_W-1:0];
      REG_GAIN_D:  set_gain_d  = value[GAIN_W-1:0];
      REG_REVERSE: set_reverse = value[0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_regs(input int center, input int base,
                              input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gi,
                              input logic [GAIN_W-1:0] gd, input logic rev);
    reg_write(REG_CENTER, DATA_W'(center));
    reg_write(REG_BASE, DATA_W'(base));
    reg_write(REG_GAIN_P, DATA_W'(gp));
    reg_write(REG_GAIN_I, DATA_W'(gi));
    reg_write(REG_GAIN_D, DATA_W'(gd));
    reg_write(REG_REVERSE, DATA_W'(rev));
  endtask

  task automatic run_random(input idle_mode_t mode, input int count);
    set_idle(mode);
    repeat (count) sample_q.push_back(random_sample());
    wait_idle();
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Reset defaults: position extremes, zero error, clear in the middle of
    // a run, and repeated far-off samples to build up the integral.
    set_idle(IDLE_NONE);
    queue_item(CMD_CLEAR, 0);
    queue_item(CMD_SAMPLE, 1500);
    queue_item(CMD_SAMPLE, 0);
    queue_item(CMD_SAMPLE, POS_FULL);
    queue_item(CMD_SAMPLE, POS_SPAN);
    queue_item(CMD_SAMPLE, 1500);
    queue_item(CMD_CLEAR, POS_FULL);
    queue_item(CMD_SAMPLE, 0);
    queue_item(CMD_SAMPLE, 0);
    queue_item(CMD_SAMPLE, 0);
    wait_idle();

    // Unit proportional gain: drive one motor to exactly zero, then push
    // each motor negative far enough to saturate the duty.
    program_regs(1500, 100, GAIN_W'(1 << GAIN_FRAC_BITS), '0, '0, 1'b0);
    queue_item(CMD_CLEAR, 0);
    queue_item(CMD_SAMPLE, 1400);
    queue_item(CMD_SAMPLE, 1600);
    queue_item(CMD_SAMPLE, 1000);
    queue_item(CMD_SAMPLE, 2000);
    wait_idle();

    // Same cases in reverse: zero speed now reads backward.
    reg_write(REG_REVERSE, DATA_W'(1));
    queue_item(CMD_SAMPLE, 1400);
    queue_item(CMD_SAMPLE, 1000);
    queue_item(CMD_SAMPLE, 1500);
    wait_idle();

    // Register extremes: everything saturates, then no correction at all,
    // then an out-of-range setpoint with maximum gains.
    program_regs(0, 0, '1, '1, '1, 1'b1);
    run_random(IDLE_SENDER, 150);
    program_regs(POS_SPAN, 255, '0, '0, '0, 1'b0);
    run_random(IDLE_RECEIVER, 100);
    program_regs(POS_FULL, 255, '1, '1, '1, 1'b0);
    run_random(IDLE_BOTH, 150);

    // Random settings, cycling through every idling pattern.
    for (int k = 0; k < 6; k++) begin
      program_regs(($urandom_range(9) == 0) ? POS_FULL : $urandom_range(POS_SPAN),
                   $urandom_range(255), random_gain(), random_gain(), random_gain(),
                   1'($urandom_range(1)));
      run_random(idle_mode_t'(k % 4), 130);
    end

    if (mismatch_count == 0) begin
      $display("PASS line_follow_pid_motor_drive_top");
    end else begin
      $display("FAIL line_follow_pid_motor_drive_top");
    end
    $finish;
  end

endmodule

### filelist.f
design/lfpd_pkg.sv
design/lfpd_apb_regs.sv
design/lfpd_err_stage.sv
design/lfpd_mult_stage.sv
design/lfpd_drive_stage.sv
design/line_follow_pid_motor_drive_top.sv
design/lfpd_checker.sv
sim/line_follow_pid_motor_drive_top_tb.sv
